// File: sv/stable_priority_queue_assert.svh
// ----------------------------------------------------------------------------
// Stable priority queue assertion macros
// Shared helpers for the concurrent checks on the queue's stream ports.
// ----------------------------------------------------------------------------
`ifndef STABLE_PRIORITY_QUEUE_ASSERT_SVH
`define STABLE_PRIORITY_QUEUE_ASSERT_SVH

// Check that cond holds at every rising clock edge outside reset.
`define SPQ_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("%m: check failed");

// Check that cons holds in the same cycle whenever ante holds.
`define SPQ_ASSERT_IMPLIES(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");

// Check that cons holds in the cycle after ante held.
`define SPQ_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

// File: sv/spq_pkg.sv
// ----------------------------------------------------------------------------
// Stable priority queue package
// Shared codes, widths and control types of the priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int unsigned FIELD_VALUE_W = 16;
	localparam int unsigned PRIO_W        = 3;
	localparam int unsigned OCC_W         = 5;

	localparam logic FUNC_ENQ = 1'b0;
	localparam logic FUNC_DEQ = 1'b1;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Per-cycle command broadcast to every cell of the chain.
	typedef struct packed {
		logic enq;
		logic deq;
	} cell_ctrl_t;

endpackage

// File: sv/spq_cell.sv
// ----------------------------------------------------------------------------
// Priority queue cell
// One slot of the sorted chain: holds an entry, keeps it, takes the new
// entry, or takes its neighbor's entry on insert and remove.
// ----------------------------------------------------------------------------
module spq_cell import spq_pkg::*; #(
	parameter int unsigned VW = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cell_ctrl_t        ctrl,
	input  logic [VW-1:0]     new_value,
	input  logic [PRIO_W-1:0] new_prio,
	input  logic              prev_keep,
	input  logic              prev_valid,
	input  logic [VW-1:0]     prev_value,
	input  logic [PRIO_W-1:0] prev_prio,
	input  logic              next_valid,
	input  logic [VW-1:0]     next_value,
	input  logic [PRIO_W-1:0] next_prio,
	output logic              keep,
	output logic              valid,
	output logic [VW-1:0]     value,
	output logic [PRIO_W-1:0] prio
);

	logic              valid_q;
	logic [VW-1:0]     value_q;
	logic [PRIO_W-1:0] prio_q;

	// Stay in place when this entry ranks at or above the newcomer.
	assign keep  = valid_q && (prio_q >= new_prio);
	assign valid = valid_q;
	assign value = value_q;
	assign prio  = prio_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.enq && !keep) begin
			valid_q <= prev_keep ? 1'b1 : prev_valid;
		end else if (ctrl.deq) begin
			valid_q <= next_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.enq && !keep) begin
			value_q <= prev_keep ? new_value : prev_value;
			prio_q  <= prev_keep ? new_prio : prev_prio;
		end else if (ctrl.deq) begin
			value_q <= next_value;
			prio_q  <= next_prio;
		end
	end

endmodule

// File: sv/stable_priority_queue.sv
// ----------------------------------------------------------------------------
// Stable priority queue
// Bounded priority queue kept sorted in a chain of cells, highest first.
// ----------------------------------------------------------------------------
// The queue holds up to QUEUE_DEPTH entries in a row of cells, cell 0 being
// the head. Every cell compares its own priority with the incoming one at the
// same time, so an enqueue finds its place and shifts the lower entries one
// cell down in the same cycle, and a dequeue pulls the whole row one cell up.
// Entries of equal priority keep their arrival order. Each input transaction
// gives exactly one output transaction, registered, in the cycle after it is
// taken. The queue takes one transaction per clock; it only waits when the
// output register still holds a result that the sink has not taken, since
// s_tready follows m_tready through that single output register. An enqueue
// on a full queue is dropped with status full; a dequeue on an empty queue
// returns status empty with zero value and priority. Values are kept at
// VALUE_BITS bits (at most the 16 bits of the field) and returned
// zero-extended.
// ----------------------------------------------------------------------------
module stable_priority_queue import spq_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = 16,
	parameter int unsigned VALUE_BITS  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [15:0] value_in, [18:16] priority_in, [23:19] zero
	input  logic [0:0]  s_tuser,   // [0] func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [15:0] value_out, [18:16] priority_out, [23:19] occupancy
	output logic [2:0]  m_tuser    // [0] out_valid, [2:1] status
);

	// Stored value width: the field never carries more than 16 bits.
	localparam int unsigned VW = (VALUE_BITS < FIELD_VALUE_W) ? VALUE_BITS : FIELD_VALUE_W;
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

	// Unpack the input transaction.
	logic              in_func;
	logic [VW-1:0]     in_value;
	logic [PRIO_W-1:0] in_prio;

	assign in_func  = s_tuser[0];
	assign in_value = s_tdata[VW-1:0];
	assign in_prio  = s_tdata[FIELD_VALUE_W +: PRIO_W];

	// Output register, parts the source from the sink.
	logic                     m_valid_q;
	logic [FIELD_VALUE_W-1:0] m_value_q;
	logic [PRIO_W-1:0]        m_prio_q;
	logic                     m_hit_q;
	status_t                  m_status_q;
	logic [OCC_W-1:0]         m_occ_q;

	logic accept;

	assign s_tready = !m_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	// Entry count and its decisions.
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_d;
	logic          full;
	logic          empty;

	assign full  = (count_q == CW'(QUEUE_DEPTH));
	assign empty = (count_q == '0);

	cell_ctrl_t ctrl;

	assign ctrl.enq = accept && (in_func == FUNC_ENQ) && !full;
	assign ctrl.deq = accept && (in_func == FUNC_DEQ) && !empty;

	always_comb begin
		count_d = count_q;
		if (ctrl.enq) begin
			count_d = count_q + CW'(1);
		end else if (ctrl.deq) begin
			count_d = count_q - CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

	// Chain of cells; cell 0 is the head of the queue.
	logic              c_keep  [QUEUE_DEPTH];
	logic              c_valid [QUEUE_DEPTH];
	logic [VW-1:0]     c_value [QUEUE_DEPTH];
	logic [PRIO_W-1:0] c_prio  [QUEUE_DEPTH];

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic              up_keep;
		logic              up_valid;
		logic [VW-1:0]     up_value;
		logic [PRIO_W-1:0] up_prio;
		logic              dn_valid;
		logic [VW-1:0]     dn_value;
		logic [PRIO_W-1:0] dn_prio;

		// The head has nothing above it that could stay ahead of the newcomer.
		if (i == 0) begin : g_head
			assign up_keep  = 1'b1;
			assign up_valid = 1'b0;
			assign up_value = '0;
			assign up_prio  = '0;
		end else begin : g_body
			assign up_keep  = c_keep[i-1];
			assign up_valid = c_valid[i-1];
			assign up_value = c_value[i-1];
			assign up_prio  = c_prio[i-1];
		end

		// The tail pulls in an empty slot on dequeue.
		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign dn_valid = 1'b0;
			assign dn_value = '0;
			assign dn_prio  = '0;
		end else begin : g_link
			assign dn_valid = c_valid[i+1];
			assign dn_value = c_value[i+1];
			assign dn_prio  = c_prio[i+1];
		end

		spq_cell #(
			.VW(VW)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.new_value (in_value),
			.new_prio  (in_prio),
			.prev_keep (up_keep),
			.prev_valid(up_valid),
			.prev_value(up_value),
			.prev_prio (up_prio),
			.next_valid(dn_valid),
			.next_value(dn_value),
			.next_prio (dn_prio),
			.keep      (c_keep[i]),
			.valid     (c_valid[i]),
			.value     (c_value[i]),
			.prio      (c_prio[i])
		);
	end

	// Build the result of the accepted transaction.
	logic [31:0] occ_wide;

	assign occ_wide = 32'(count_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (accept) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_value_q  <= '0;
			m_prio_q   <= '0;
			m_hit_q    <= 1'b0;
			m_status_q <= ST_OK;
			m_occ_q    <= occ_wide[OCC_W-1:0];
			if (in_func == FUNC_ENQ) begin
				// Drop the entry when every slot is taken.
				if (full) begin
					m_status_q <= ST_FULL;
				end
			end else if (empty) begin
				m_status_q <= ST_EMPTY;
			end else begin
				// Return the head entry as it stands before the shift.
				m_value_q <= FIELD_VALUE_W'(c_value[0]);
				m_prio_q  <= c_prio[0];
				m_hit_q   <= 1'b1;
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {m_occ_q, m_prio_q, m_value_q};
	assign m_tuser  = {m_status_q, m_hit_q};

endmodule

// File: sv/spq_checker.sv
// ----------------------------------------------------------------------------
// Stable priority queue checker
// Port-level checks on the queue's output transactions, bound to the top.
// ----------------------------------------------------------------------------
`include "stable_priority_queue_assert.svh"

module spq_checker import spq_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = 16
) (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic [2:0]  m_tuser
);

	logic             hit;
	logic [1:0]       status;
	logic [OCC_W-1:0] occ;
	logic [31:0]      depth_wide;
	logic [26:0]      beat;

	assign hit        = m_tuser[0];
	assign status     = m_tuser[2:1];
	assign occ        = m_tdata[23:19];
	assign depth_wide = 32'(QUEUE_DEPTH);
	assign beat       = {m_tuser, m_tdata};

	// Hold a stalled result.
	`SPQ_ASSERT_NEXT(a_hold_stalled, m_tvalid && !m_tready, m_tvalid && $stable(beat))

	// A returned entry always comes with status ok.
	`SPQ_ASSERT_IMPLIES(a_hit_is_ok, m_tvalid && hit, status == ST_OK)

	// A dropped enqueue only happens at full occupancy.
	`SPQ_ASSERT_IMPLIES(a_full_occ, m_tvalid && status == ST_FULL, !hit && occ == depth_wide[OCC_W-1:0])

	// A dequeue on empty returns nothing and leaves the queue empty.
	`SPQ_ASSERT_IMPLIES(a_empty_zero, m_tvalid && status == ST_EMPTY, !hit && m_tdata == 24'd0)

endmodule

bind stable_priority_queue spq_checker #(
	.QUEUE_DEPTH(QUEUE_DEPTH)
) u_spq_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stable priority queue testbench
// Runs a directed table and then random enqueue and dequeue traffic through
// the stream ports. Results are checked against a local sorted-queue model
// or a typed table row, random traffic under several idle and backpressure mixes.
// ----------------------------------------------------------------------------
module tb_top import spq_pkg::*; ();

	localparam int QDEPTH      = 16;
	localparam int CYCLE_LIMIT = 200000;
	localparam int MAX_REPORTS = 10;
	localparam int RAND_PHASES = 4;
	localparam int PHASE_ITEMS = 450;
	localparam int BLOCK_ITEMS = 30;
	localparam int DIR_COUNT   = 24;

	// One result transaction, unpacked from m_tdata and m_tuser.
	typedef struct packed {
		logic [15:0] value;
		logic [2:0]  prio;
		logic        valid;
		status_t     status;
		logic [4:0]  occupancy;
	} result_t;

	// One row of the directed table. When typed is set, exp is the result
	// to check; otherwise the model supplies it.
	typedef struct packed {
		logic        func;
		logic [15:0] value;
		logic [2:0]  prio;
		logic        typed;
		result_t     exp;
	} dir_row_t;

	localparam result_t NO_RES = '{16'h0000, 3'd0, 1'b0, ST_OK, 5'd0};

	// Fill the queue with mixed priorities and ties, push once more while
	// full, then drain part of it. Dequeue rows carry junk value/priority
	// that the block must ignore.
	localparam dir_row_t DIR_ROWS [DIR_COUNT] = '{
		'{FUNC_DEQ, 16'h0000, 3'd0, 1'b1, '{16'h0000, 3'd0, 1'b0, ST_EMPTY, 5'd0}},
		'{FUNC_ENQ, 16'hFFFF, 3'd7, 1'b1, '{16'h0000, 3'd0, 1'b0, ST_OK, 5'd1}},
		'{FUNC_ENQ, 16'h0000, 3'd0, 1'b0, NO_RES},
		'{FUNC_ENQ, 16'h1234, 3'd7, 1'b0, NO_RES},
		'{FUNC_ENQ, 16'hAAAA, 3'd3, 1'b0, NO_RES},
		'{FUNC_ENQ, 16'h5555, 3'd3, 1'b0, NO_RES},
		'{FUNC_ENQ, 16'h0001, 3'd5, 1'b0, NO_RES},
		'{FUNC_ENQ, 16'h8000, 3'd1, 1'b0, NO_RES},
		'{FUNC_ENQ, 16'h7FFF, 3'd6, 1'b0, NO_RES},
		'{FUNC_ENQ, 16'h00FF, 3'd2, 1'b0, NO_RES},
		'{FUNC_ENQ, 16'hFF00, 3'd4, 1'b0, NO_RES},
		'{FUNC_ENQ, 16'h0F0F, 3'd7, 1'b0, NO_RES},
		'{FUNC_ENQ, 16'hF0F0, 3'd0, 1'b0, NO_RES},
		'{FUNC_ENQ, 16'h3C3C, 3'd3, 1'b0, NO_RES},
		'{FUNC_ENQ, 16'hC3C3, 3'd5, 1'b0, NO_RES},
		'{FUNC_ENQ, 16'h6666, 3'd6, 1'b0, NO_RES},
		'{FUNC_ENQ, 16'h9999, 3'd1, 1'b0, NO_RES},
		'{FUNC_ENQ, 16'hBEEF, 3'd7, 1'b1, '{16'h0000, 3'd0, 1'b0, ST_FULL, 5'd16}},
		'{FUNC_DEQ, 16'hDEAD, 3'd5, 1'b1, '{16'hFFFF, 3'd7, 1'b1, ST_OK, 5'd15}},
		'{FUNC_DEQ, 16'hFFFF, 3'd7, 1'b0, NO_RES},
		'{FUNC_DEQ, 16'h0000, 3'd0, 1'b0, NO_RES},
		'{FUNC_DEQ, 16'hDEAD, 3'd2, 1'b0, NO_RES},
		'{FUNC_DEQ, 16'h5A5A, 3'd6, 1'b0, NO_RES},
		'{FUNC_DEQ, 16'hA5A5, 3'd1, 1'b0, NO_RES}
	};

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;   // [15:0] value_in, [18:16] priority_in, [23:19] zero
	logic [0:0]  s_tuser;   // [0] func
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;   // [15:0] value_out, [18:16] priority_out, [23:19] occupancy
	logic [2:0]  m_tuser;   // [0] out_valid, [2:1] status

	// Model of the queue contents, head at index 0.
	logic [15:0] held_values [QDEPTH];
	logic [2:0]  held_prios  [QDEPTH];
	int          held_count;

	result_t     expected_results [$];
	int          mismatch_count;
	int          cycle_count;
	int          idle_pct;
	int          stall_pct;

	// Typed expectation for the transaction currently on the slave side.
	logic        cur_typed;
	result_t     cur_exp;

	stable_priority_queue #(
		.QUEUE_DEPTH(QDEPTH),
		.VALUE_BITS (16)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	always #5 clk = ~clk;

	// Apply one operation to the model and return the result it gives.
	// Enqueue goes behind every entry of equal or higher priority, which
	// keeps ties in arrival order.
	function automatic result_t predict_queue_op(input logic func,
			input logic [15:0] value, input logic [2:0] prio);
		result_t r;
		int      pos;
		r = NO_RES;
		if (func == FUNC_ENQ) begin
			if (held_count >= QDEPTH) begin
				r.status = ST_FULL;
			end else begin
				pos = 0;
				while (pos < held_count && held_prios[pos] >= prio)
					pos++;
				for (int i = held_count; i > pos; i--) begin
					held_values[i] = held_values[i-1];
					held_prios[i]  = held_prios[i-1];
				end
				held_values[pos] = value;
				held_prios[pos]  = prio;
				held_count++;
			end
		end else begin
			if (held_count == 0) begin
				r.status = ST_EMPTY;
			end else begin
				r.value = held_values[0];
				r.prio  = held_prios[0];
				r.valid = 1'b1;
				for (int i = 1; i < held_count; i++) begin
					held_values[i-1] = held_values[i];
					held_prios[i-1]  = held_prios[i];
				end
				held_count--;
			end
		end
		r.occupancy = held_count[4:0];
		return r;
	endfunction

	// Present one operation on the slave side. Idle beforehand at the
	// current rate, then hold tvalid until the transaction is taken. Enter
	// and leave on a falling edge so valid stays high across back-to-back
	// transactions.
	task automatic send_op(input logic func, input logic [15:0] value,
			input logic [2:0] prio, input logic typed, input result_t exp);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid  <= 1'b1;
		s_tuser   <= func;
		s_tdata   <= {5'd0, prio, value};
		cur_typed <= typed;
		cur_exp   <= exp;
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
	endtask

	// Hold off the sender until every pending result has come back.
	task automatic wait_drained();
		while (expected_results.size() != 0)
			@(negedge clk);
	endtask

	// Random receiver stalls, updated away from the sampling edge.
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	// Sample both handshakes at the rising edge. Record the prediction
	// before checking the output so ordering holds for any latency.
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				want = predict_queue_op(s_tuser[0], s_tdata[15:0], s_tdata[18:16]);
				if (cur_typed)
					want = cur_exp;
				expected_results.push_back(want);
			end
			if (m_tvalid && m_tready) begin
				got = '{m_tdata[15:0], m_tdata[18:16], m_tuser[0],
					status_t'(m_tuser[2:1]), m_tdata[23:19]};
				if (expected_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("ERROR: result with no transaction pending:",
							" value=%h prio=%0d valid=%0b status=%0d occ=%0d",
							got.value, got.prio, got.valid, got.status, got.occupancy);
				end else begin
					want = expected_results.pop_front();
					if (got != want) begin
						mismatch_count++;
						if (mismatch_count <= MAX_REPORTS)
							$display("ERROR: result mismatch:",
								" exp value=%h prio=%0d valid=%0b status=%0d occ=%0d,",
								want.value, want.prio, want.valid, want.status,
								want.occupancy,
								" got value=%h prio=%0d valid=%0b status=%0d occ=%0d",
								got.value, got.prio, got.valid, got.status,
								got.occupancy);
					end
				end
			end
		end
	end

	// Watchdog: end the run if traffic stops making progress.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		int          enq_pct;
		logic        narrow;
		logic [2:0]  prio_base;
		logic        func;
		logic [15:0] value;
		logic [2:0]  prio;
		clk            = 1'b0;
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		s_tuser        = '0;
		m_tready       = 1'b0;
		cur_typed      = 1'b0;
		cur_exp        = NO_RES;
		held_count     = 0;
		mismatch_count = 0;
		cycle_count    = 0;
		idle_pct       = 0;
		stall_pct      = 0;
		enq_pct        = 50;
		narrow         = 1'b0;
		prio_base      = '0;
		for (int i = 0; i < QDEPTH; i++) begin
			held_values[i] = '0;
			held_prios[i]  = '0;
		end

		// Single reset pulse at the start of the run.
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Walk the directed table at full rate.
		for (int r = 0; r < DIR_COUNT; r++)
			send_op(DIR_ROWS[r].func, DIR_ROWS[r].value, DIR_ROWS[r].prio,
				DIR_ROWS[r].typed, DIR_ROWS[r].exp);

		// Random traffic, one idle/stall mix per phase.
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			// Drop valid and wait for every outstanding result first.
			s_tvalid <= 1'b0;
			@(negedge clk);
			wait_drained();
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 56; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 56; end
				default: begin idle_pct = 8; stall_pct = 8; end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// Switch regime per block: fill toward full, drain toward
				// empty, or hover; sometimes crowd priorities for ties.
				if (n % BLOCK_ITEMS == 0) begin
					case ($urandom_range(2))
						0: enq_pct = 85;
						1: enq_pct = 15;
						default: enq_pct = 50;
					endcase
					narrow    = 1'($urandom_range(1));
					prio_base = 3'($urandom_range(7));
				end
				func = ($urandom_range(99) < enq_pct) ? FUNC_ENQ : FUNC_DEQ;
				case ($urandom_range(15))
					0: value = 16'h0000;
					1: value = 16'hFFFF;
					default: value = 16'($urandom_range(16'hFFFF));
				endcase
				prio = narrow ? (prio_base + 3'($urandom_range(1))) : 3'($urandom_range(7));
				send_op(func, value, prio, 1'b0, NO_RES);
			end
		end

		// Let the tail drain with the sink always ready.
		s_tvalid <= 1'b0;
		stall_pct = 0;
		wait_drained();
		repeat (8) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
